// File: design/pbw_pkg.sv
// Shared types and codes for the protobuf wire field parser.
`default_nettype none

package pbw_pkg;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_SKIP    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd4;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENDELIM = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_last;
    } in_word_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        field_done;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic        message_done;
        logic [2:0]  status;
    } out_word_t;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] acc;
        logic [3:0]  count;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] remaining;
        logic [2:0]  error_code;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_KEY,
        acc:          64'd0,
        count:        4'd0,
        field_number: 32'd0,
        wire_type:    3'd0,
        remaining:    64'd0,
        error_code:   ST_OK
    };

endpackage

`default_nettype wire

// File: design/pbw_decode.sv
// Per-byte decode: next parser state and result word from current state and one input word.
`default_nettype none

module pbw_decode
    import pbw_pkg::*;
(
    input  parse_state_t state,
    input  in_word_t     word,
    output parse_state_t state_next,
    output out_word_t    result,
    output logic         has_result
);

    logic [63:0] chunk;
    logic [6:0]  shamt;
    logic [63:0] acc_take;
    logic [3:0]  count_inc;
    logic        v_done;
    logic        v_long;
    logic [63:0] remaining_dec;
    parse_state_t nxt;
    logic        fd;
    logic [63:0] fval;

    function automatic parse_state_t set_error(parse_state_t s, logic [2:0] code);
        parse_state_t r;
        r            = s;
        r.error_code = code;
        r.phase      = PH_ERROR;
        r.acc        = 64'd0;
        r.count      = 4'd0;
        return r;
    endfunction

    // 7 data bits per varint byte; past ten bytes nothing is merged
    assign shamt     = 7'(state.count) * 7'd7;
    assign chunk     = (state.count < VARINT_MAX_BYTES)
                       ? ({57'd0, word.data_byte[6:0]} << shamt) : 64'd0;
    assign acc_take  = state.acc | chunk;
    assign count_inc = state.count + 4'd1;
    assign v_done    = !word.data_byte[7];
    assign v_long    = word.data_byte[7] && (count_inc >= VARINT_MAX_BYTES);
    assign remaining_dec = state.remaining - 64'd1;

    always_comb
    begin
        nxt  = state;
        fd   = 1'b0;
        fval = 64'd0;
        result = '0;
        case (state.phase)
            PH_KEY:
            begin
                nxt.acc   = acc_take;
                nxt.count = count_inc;
                if (v_long)
                begin
                    nxt = set_error(nxt, ST_TOO_LONG);
                end
                else if (v_done)
                begin
                    nxt.acc   = 64'd0;
                    nxt.count = 4'd0;
                    if (acc_take == 64'd0)
                    begin
                        nxt = set_error(nxt, ST_ZERO_KEY);
                    end
                    else
                    begin
                        nxt.field_number = acc_take[34:3];
                        nxt.wire_type    = acc_take[2:0];
                        case (acc_take[2:0])
                            WT_VARINT:   nxt.phase = PH_VALUE;
                            WT_LENDELIM: nxt.phase = PH_LENGTH;
                            WT_FIXED64:
                            begin
                                nxt.remaining = 64'd8;
                                nxt.phase     = PH_SKIP;
                            end
                            WT_FIXED32:
                            begin
                                nxt.remaining = 64'd4;
                                nxt.phase     = PH_SKIP;
                            end
                            default:     nxt = set_error(nxt, ST_BAD_TYPE);
                        endcase
                    end
                end
            end
            PH_VALUE:
            begin
                nxt.acc   = acc_take;
                nxt.count = count_inc;
                if (v_long)
                begin
                    nxt = set_error(nxt, ST_TOO_LONG);
                end
                else if (v_done)
                begin
                    fd        = 1'b1;
                    fval      = acc_take;
                    nxt.acc   = 64'd0;
                    nxt.count = 4'd0;
                    nxt.phase = PH_KEY;
                end
            end
            PH_LENGTH:
            begin
                nxt.acc   = acc_take;
                nxt.count = count_inc;
                if (v_long)
                begin
                    nxt = set_error(nxt, ST_TOO_LONG);
                end
                else if (v_done)
                begin
                    // length stays in acc and is reported when the payload ends
                    nxt.count = 4'd0;
                    if (acc_take == 64'd0)
                    begin
                        fd        = 1'b1;
                        nxt.phase = PH_KEY;
                    end
                    else
                    begin
                        nxt.remaining = acc_take;
                        nxt.phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_SKIP:
            begin
                nxt.remaining = remaining_dec;
                if (remaining_dec == 64'd0)
                begin
                    fd        = 1'b1;
                    nxt.phase = PH_KEY;
                end
            end
            PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = word.data_byte;
                nxt.remaining        = remaining_dec;
                if (remaining_dec == 64'd0)
                begin
                    fd        = 1'b1;
                    fval      = state.acc;
                    nxt.acc   = 64'd0;
                    nxt.phase = PH_KEY;
                end
            end
            default:
            begin
                // error phase and unused codes: swallow bytes
            end
        endcase

        result.field_done   = fd;
        result.field_number = fd ? nxt.field_number : 32'd0;
        result.wire_type    = fd ? nxt.wire_type : 3'd0;
        result.field_value  = fval;

        if (word.message_last)
        begin
            result.message_done = 1'b1;
            if (nxt.error_code != ST_OK)
                result.status = nxt.error_code;
            else if (nxt.phase != PH_KEY || nxt.count != 4'd0)
                result.status = ST_TRUNCATED;
            else
                result.status = ST_OK;
            nxt = STATE_RESET;
        end

        state_next = nxt;
        has_result = result.payload_valid || result.field_done || result.message_done;
    end

endmodule

`default_nettype wire

// File: design/protobuf_wire_field_parser_core.sv
// Top level of the streaming protobuf wire field parser.
//
// Input channel msg: one word per cycle, a message byte plus a last-byte flag,
// moved when msg_valid is high and msg_stall is low.
// Output channel res: one result word per input word that has a field event, a
// payload byte or a message end; words with nothing to report are dropped.
// Throughput is one input word per cycle, sustained while res_stall is low; the
// byte decode is a single pass of logic from the input register into the result
// register, with the 64-bit remaining-length decrement as the longest path.
// A word accepted into the input register is decoded into the result register, which drives res.
// The result register and the input register give one word of slack: while a
// result waits under res_stall, an empty input register still takes one word;
// a full one raises msg_stall in the same cycle until the result is taken.
// Words that make no result still wait behind a stalled result, so the parser
// state follows input order exactly.
// Reset clears the parser state to awaiting a key and empties both registers.
// After the last byte of a message the parser returns to that state by itself.
`default_nettype none

module protobuf_wire_field_parser_core
    import pbw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      msg_valid,
    output logic           msg_stall,
    input  wire in_word_t  msg,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_word_t      res
);

    logic         in_valid_reg;
    in_word_t     in_word_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    out_word_t    out_word_reg;
    logic         out_valid_reg;
    out_word_t    dec_result;
    logic         dec_has_result;
    logic         adv;

    pbw_decode u_decode (
        .state      (state_reg),
        .word       (in_word_reg),
        .state_next (state_next),
        .result     (dec_result),
        .has_result (dec_has_result)
    );

    assign adv       = in_valid_reg && (!out_valid_reg || !res_stall);
    assign msg_stall = in_valid_reg && !adv;
    assign res_valid = out_valid_reg;
    assign res       = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (msg_valid && !msg_stall)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv)
            begin
                state_reg     <= state_next;
                out_valid_reg <= dec_has_result;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
            in_word_reg <= msg;
        if (adv)
            out_word_reg <= dec_result;
    end

    a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_ERROR |-> state_reg.error_code != ST_OK)
        else $error("error phase without an error code");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.payload_valid || res.field_done || res.message_done))
        else $error("empty result word delivered");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_word_reg.message_last)
        |=> (state_reg.phase == PH_KEY && state_reg.count == 4'd0
             && state_reg.error_code == ST_OK))
        else $error("parser not back at key after last byte");

    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.message_done) |-> res.status == ST_OK)
        else $error("status set on a word that is not a message end");

    a_value_on_field: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.field_done) |-> res.field_value == 64'd0)
        else $error("field value without field done");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for protobuf_wire_field_parser_core: directed and random messages checked per word.
`timescale 1ns / 100ps

module tb;
    import pbw_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1550;
    localparam int CALM_FROM      = 400;
    localparam int CALM_TO        = 700;
    localparam int PAUSE_AT       = 900;

    // wire types the parser rejects
    localparam logic [2:0] WT_SGROUP  = 3'd3;
    localparam logic [2:0] WT_EGROUP  = 3'd4;
    localparam logic [2:0] WT_UNUSED6 = 3'd6;
    localparam logic [2:0] WT_UNUSED7 = 3'd7;

    typedef enum logic [1:0] {VARINT_MORE, VARINT_END, VARINT_OVERRUN} varint_step_t;

    class wire_parse_tracker;
        phase_t      ph;
        logic [63:0] acc;
        logic [3:0]  nbytes;
        logic [31:0] fnum;
        logic [2:0]  wtype;
        logic [63:0] left;
        logic [2:0]  err;
        out_word_t   reports_due[$];
        int          mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            ph     = PH_KEY;
            acc    = '0;
            nbytes = '0;
            fnum   = '0;
            wtype  = '0;
            left   = '0;
            err    = ST_OK;
        endfunction

        function void enter_error(logic [2:0] code);
            err    = code;
            ph     = PH_ERROR;
            acc    = '0;
            nbytes = '0;
        endfunction

        function varint_step_t take_varint(logic [7:0] b);
            // the tenth byte contributes only bit 63
            if (nbytes < VARINT_MAX_BYTES)
                acc = acc | (64'(b[6:0]) << (7 * nbytes));
            nbytes = nbytes + 4'd1;
            if (!b[7])
                return VARINT_END;
            if (nbytes >= VARINT_MAX_BYTES)
                return VARINT_OVERRUN;
            return VARINT_MORE;
        endfunction

        function void take_byte(in_word_t w);
            out_word_t    r;
            varint_step_t vs;
            logic [63:0]  key;
            r = '0;
            case (ph)
                PH_KEY:
                begin
                    vs = take_varint(w.data_byte);
                    if (vs == VARINT_OVERRUN)
                        enter_error(ST_TOO_LONG);
                    else if (vs == VARINT_END)
                    begin
                        key    = acc;
                        acc    = '0;
                        nbytes = '0;
                        if (key == 64'd0)
                            enter_error(ST_ZERO_KEY);
                        else
                        begin
                            fnum  = key[34:3];
                            wtype = key[2:0];
                            case (wtype)
                                WT_VARINT:   ph = PH_VALUE;
                                WT_LENDELIM: ph = PH_LENGTH;
                                WT_FIXED64:
                                begin
                                    left = 64'd8;
                                    ph   = PH_SKIP;
                                end
                                WT_FIXED32:
                                begin
                                    left = 64'd4;
                                    ph   = PH_SKIP;
                                end
                                default:     enter_error(ST_BAD_TYPE);
                            endcase
                        end
                    end
                end
                PH_VALUE:
                begin
                    vs = take_varint(w.data_byte);
                    if (vs == VARINT_OVERRUN)
                        enter_error(ST_TOO_LONG);
                    else if (vs == VARINT_END)
                    begin
                        r.field_done  = 1'b1;
                        r.field_value = acc;
                        acc           = '0;
                        nbytes        = '0;
                        ph            = PH_KEY;
                    end
                end
                PH_LENGTH:
                begin
                    vs = take_varint(w.data_byte);
                    if (vs == VARINT_OVERRUN)
                        enter_error(ST_TOO_LONG);
                    else if (vs == VARINT_END)
                    begin
                        nbytes = '0;
                        if (acc == 64'd0)
                        begin
                            r.field_done = 1'b1;
                            ph           = PH_KEY;
                        end
                        else
                        begin
                            // acc keeps the length for the report at the end of the payload
                            left = acc;
                            ph   = PH_PAYLOAD;
                        end
                    end
                end
                PH_SKIP:
                begin
                    left = left - 64'd1;
                    if (left == 64'd0)
                    begin
                        r.field_done = 1'b1;
                        ph           = PH_KEY;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = w.data_byte;
                    left            = left - 64'd1;
                    if (left == 64'd0)
                    begin
                        r.field_done  = 1'b1;
                        r.field_value = acc;
                        acc           = '0;
                        ph            = PH_KEY;
                    end
                end
                default: ;
            endcase
            if (r.field_done)
            begin
                r.field_number = fnum;
                r.wire_type    = wtype;
            end
            if (w.message_last)
            begin
                r.message_done = 1'b1;
                if (err != ST_OK)
                    r.status = err;
                else if (ph != PH_KEY || nbytes != 4'd0)
                    r.status = ST_TRUNCATED;
                else
                    r.status = ST_OK;
                restart();
            end
            if (r.payload_valid || r.field_done || r.message_done)
                reports_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_report(out_word_t got);
            out_word_t want;
            if (reports_due.size() == 0)
            begin
                $error("result word with no report due: %h", got);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("payload_valid", 64'(want.payload_valid), 64'(got.payload_valid));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("field_done", 64'(want.field_done), 64'(got.field_done));
            compare_field("field_number", 64'(want.field_number), 64'(got.field_number));
            compare_field("wire_type", 64'(want.wire_type), 64'(got.wire_type));
            compare_field("field_value", want.field_value, got.field_value);
            compare_field("message_done", 64'(want.message_done), 64'(got.message_done));
            compare_field("status", 64'(want.status), 64'(got.status));
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       msg_valid = 1'b0;
    logic       msg_stall;
    in_word_t   msg       = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    out_word_t  res;
    bit         gaps_on   = 1'b1;
    int         words_sent = 0;
    logic [7:0] bytes_q[$];

    wire_parse_tracker tracker = new();

    protobuf_wire_field_parser_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            tracker.match_report(res);
        res_stall <= gaps_on && ($urandom_range(0, 99) < 25);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((msg_valid && !msg_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pad_bytes();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    // extra continuation bytes give non-minimal encodings; junk_top sets bits dropped past 64
    function automatic void put_varint(logic [63:0] v, int unsigned extra, bit junk_top);
        int unsigned n;
        int unsigned i;
        logic [7:0]  b;
        n = 1;
        while (n < VARINT_MAX_BYTES && (v >> (7 * n)) != 64'd0)
            n++;
        n = (n + extra > VARINT_MAX_BYTES) ? VARINT_MAX_BYTES : n + extra;
        for (i = 0; i < n; i++)
        begin
            b = 8'(v >> (7 * i)) & 8'h7f;
            if (i + 1 < n)
                b[7] = 1'b1;
            if (i + 1 == VARINT_MAX_BYTES && junk_top)
                b[6:1] = 6'($urandom);
            bytes_q.push_back(b);
        end
    endfunction

    function automatic logic [60:0] pick_field_number();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 61'($urandom_range(1, 15));
            6, 7:             return 61'($urandom_range(16, 16383));
            8:                return 61'($urandom);
            default:          return 61'(rand64() >> 3);
        endcase
    endfunction

    function automatic void put_field();
        logic [2:0]  wt;
        logic [63:0] len;
        case ($urandom_range(0, 3))
            0:       wt = WT_VARINT;
            1:       wt = WT_FIXED64;
            2:       wt = WT_LENDELIM;
            default: wt = WT_FIXED32;
        endcase
        put_varint({pick_field_number(), wt}, pad_bytes(), 1'($urandom));
        case (wt)
            WT_VARINT:  put_varint(rand64() >> $urandom_range(0, 63), pad_bytes(), 1'($urandom));
            WT_FIXED64: repeat (8) bytes_q.push_back(8'($urandom));
            WT_FIXED32: repeat (4) bytes_q.push_back(8'($urandom));
            default:
            begin
                len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(7, 24))
                                                  : 64'($urandom_range(0, 6));
                put_varint(len, pad_bytes(), 1'b0);
                repeat (len) bytes_q.push_back(8'($urandom));
            end
        endcase
    endfunction

    function automatic void put_overrun();
        repeat ($urandom_range(10, 12)) bytes_q.push_back(8'h80 | 8'($urandom));
    endfunction

    function automatic void put_error_token();
        logic [2:0] bad;
        case ($urandom_range(0, 3))
            0:       bad = WT_SGROUP;
            1:       bad = WT_EGROUP;
            2:       bad = WT_UNUSED6;
            default: bad = WT_UNUSED7;
        endcase
        case ($urandom_range(0, 4))
            0: put_varint(64'd0, pad_bytes(), 1'b0);
            1: put_varint({pick_field_number(), bad}, pad_bytes(), 1'b0);
            2: put_overrun();
            3:
            begin
                put_varint({pick_field_number(), WT_VARINT}, 0, 1'b0);
                put_overrun();
            end
            default:
            begin
                put_varint({pick_field_number(), WT_LENDELIM}, 0, 1'b0);
                put_overrun();
            end
        endcase
    endfunction

    task automatic send_word(in_word_t w);
        if (gaps_on && $urandom_range(0, 99) < 25)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= w;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        tracker.take_byte(w);
        words_sent++;
    endtask

    task automatic send_message();
        in_word_t w;
        int       i;
        for (i = 0; i < bytes_q.size(); i++)
        begin
            w.data_byte    = bytes_q[i];
            w.message_last = (i == bytes_q.size() - 1);
            send_word(w);
        end
        bytes_q.delete();
    endtask

    task automatic wait_for_reports();
        msg_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int kind;
        int cut;
        int start;
        bit paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key on the last byte
        bytes_q.push_back(8'h00);
        send_message();
        // field 1 with wire type 3, then an ignored byte
        bytes_q.push_back(8'h0B);
        bytes_q.push_back(8'hFF);
        send_message();
        // varint 150 completing on the last byte
        bytes_q.push_back(8'h08);
        bytes_q.push_back(8'h96);
        bytes_q.push_back(8'h01);
        send_message();
        // empty length field, then a two-byte payload ending the message
        bytes_q.push_back(8'h12);
        bytes_q.push_back(8'h00);
        bytes_q.push_back(8'h12);
        bytes_q.push_back(8'h02);
        bytes_q.push_back(8'hAA);
        bytes_q.push_back(8'h55);
        send_message();
        // fixed32 body, then a fixed64 cut short
        bytes_q.push_back(8'h0D);
        bytes_q.push_back(8'h11);
        bytes_q.push_back(8'h22);
        bytes_q.push_back(8'h33);
        bytes_q.push_back(8'h44);
        bytes_q.push_back(8'h09);
        bytes_q.push_back(8'h01);
        send_message();
        // key varint still continuing on its tenth byte
        repeat (10) bytes_q.push_back(8'hFF);
        send_message();
        wait_for_reports();

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            gaps_on = !(words_sent - start >= CALM_FROM && words_sent - start < CALM_TO);
            if (!paused && words_sent - start >= PAUSE_AT)
            begin
                paused = 1'b1;
                wait_for_reports();
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                repeat ($urandom_range(1, 5)) put_field();
            end
            else if (kind < 77)
            begin
                repeat ($urandom_range(1, 4)) put_field();
                if (bytes_q.size() > 1)
                begin
                    cut = $urandom_range(1, bytes_q.size() - 1);
                    while (bytes_q.size() > cut)
                        void'(bytes_q.pop_back());
                end
            end
            else if (kind < 89)
            begin
                repeat ($urandom_range(0, 2)) put_field();
                put_error_token();
                repeat ($urandom_range(0, 2)) put_field();
            end
            else if (kind < 94)
            begin
                // length far beyond what the message holds
                put_varint({pick_field_number(), WT_LENDELIM}, 0, 1'b0);
                put_varint((rand64() >> $urandom_range(0, 56)) | 64'd32, 0, 1'b0);
                repeat ($urandom_range(1, 5)) bytes_q.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom));
            end
            send_message();
        end

        gaps_on = 1'b1;
        wait_for_reports();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: protobuf_wire_field_parser_core.f
design/pbw_pkg.sv
design/pbw_decode.sv
design/protobuf_wire_field_parser_core.sv
dv/tb.sv
